@@ design/rrs_pkg.sv @@
// Shared types and constants for the round-robin CPU scheduler.
// No dependencies; the top level, rrs_table and rrs_engine import this package.

package rrs_pkg;

   localparam int CLOCK_BITS = 24;
   localparam logic [CLOCK_BITS-1:0] CLOCK_MAX = 24'hFFFFFF;
   localparam logic [3:0] FIN_MAX = 4'hF;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STEP  = 2'd2;

   localparam logic [1:0] KIND_SLICE = 2'd0;
   localparam logic [1:0] KIND_IDLE  = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUANTUM       = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROCESS_COUNT = 1'd1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [2:0]  entry_index;
      logic [15:0] arrival_time;
      logic [15:0] burst_time;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  step_kind;
      logic [2:0]  process_index;
      logic [7:0]  slice_length;
      logic [23:0] time_now;
      logic        finished;
      logic [23:0] turnaround;
      logic [23:0] waiting;
      logic [23:0] switch_count;
   } rsp_word_type;

   typedef struct packed {
      logic load_we;
      logic rem_we;
      logic rem_clr;
   } tbl_cmd_type;

endpackage

@@ design/round_robin_cpu_scheduler.sv @@
// Round-robin CPU scheduler top level: CSR registers, handshakes, result register.
// Depends on rrs_pkg, rrs_table and rrs_engine.
//
// Input channel req_*: one word per operation (load entry, start run, dispatch
// one step). req_stall is high while a start or step is being worked on.
// Result channel rsp_*: one word per dispatch step, none for load or start.
// CSR port csr_*: quantum (index 0) and process count (index 1), write only.
// Work per word:
//   load: no result.
//   start: burst copy sweep, then arrival scan.
//   step: a slice runs, a slice finishes its entry, an idle jump, or all entries
//   are done; the result shows on rsp_* in the same cycle as the next word can
//   be taken. The work is paced by the arrival scan over the table and the single
//   shared add/subtract unit.
// A finished result sits in the output register; the next word is accepted
// while it waits, and the following result is held until rsp_stall drops.
// Reset is synchronous: queue empty, flags and counters clear, quantum 2,
// process count 7; table contents are undefined until loaded.

module round_robin_cpu_scheduler #(
   parameter int MAX_PROCESSES = 8,
   parameter int TIME_BITS     = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rrs_pkg::req_word_type                req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rrs_pkg::rsp_word_type                rsp_data,
   input  logic                                 csr_we,
   input  logic [rrs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rrs_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   import rrs_pkg::*;

   localparam int IW = $clog2(MAX_PROCESSES);

   logic [7:0]           quantum_ff, quantum_in;
   logic [3:0]           count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_data_ff;
   logic                 busy;
   logic                 req_fire;
   tbl_cmd_type          tbl_cmd;
   logic [IW-1:0]        rd_addr;
   logic [IW-1:0]        rem_addr;
   logic [TIME_BITS-1:0] rem_wdata;
   logic [TIME_BITS-1:0] arr_q;
   logic [TIME_BITS-1:0] burst_q;
   logic [TIME_BITS-1:0] rem_q;
   logic                 res_valid;
   rsp_word_type         res_word;
   logic                 res_take;

   assign req_stall = busy;
   assign req_fire  = req_valid && !busy;
   assign res_take  = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      quantum_in = quantum_ff;
      count_in   = count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_QUANTUM:       quantum_in = csr_wdata[7:0];
            CSR_PROCESS_COUNT: count_in   = csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff   <= 8'd2;
         count_ff     <= 4'd7;
         rsp_valid_ff <= 1'b0;
      end else begin
         quantum_ff   <= quantum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res_word;
      end
   end

   rrs_table #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .TIME_BITS     (TIME_BITS)
   ) u_table (
      .clock        (clock),
      .reset        (reset),
      .cmd          (tbl_cmd),
      .load_addr    (req_data.entry_index),
      .load_arrival (req_data.arrival_time),
      .load_burst   (req_data.burst_time),
      .rd_addr      (rd_addr),
      .rem_addr     (rem_addr),
      .rem_wdata    (rem_wdata),
      .arr_q        (arr_q),
      .burst_q      (burst_q),
      .rem_q        (rem_q)
   );

   rrs_engine #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .TIME_BITS     (TIME_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_fire      (req_fire),
      .req_word      (req_data),
      .quantum       (quantum_ff),
      .process_count (count_ff),
      .busy          (busy),
      .tbl_cmd       (tbl_cmd),
      .rd_addr       (rd_addr),
      .rem_addr      (rem_addr),
      .rem_wdata     (rem_wdata),
      .arr_q         (arr_q),
      .burst_q       (burst_q),
      .rem_q         (rem_q),
      .res_valid     (res_valid),
      .res_word      (res_word),
      .res_take      (res_take)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/rrs_alu.sv @@
// Shared add/subtract unit of the scheduler sequencer.
// Depends on nothing; the result carries one extra bit (carry, or borrow for a < b).

module rrs_alu #(
   parameter int WIDTH = 24
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic             sub,
   output logic [WIDTH:0]   res
);

   logic [WIDTH:0] b_ext;

   always_comb begin
      b_ext = {1'b0, b};
      if (sub) begin
         b_ext = ~b_ext;
      end
      res = {1'b0, a} + b_ext + (WIDTH+1)'(sub);
   end

endmodule

@@ design/rrs_table.sv @@
// Process table: arrival, burst and remaining-time memories with registered reads.
// Depends on rrs_pkg; remaining times carry valid bits so unwritten entries read zero.

module rrs_table #(
   parameter int MAX_PROCESSES = 8,
   parameter int TIME_BITS     = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rrs_pkg::tbl_cmd_type              cmd,
   input  logic [2:0]                        load_addr,
   input  logic [15:0]                       load_arrival,
   input  logic [15:0]                       load_burst,
   input  logic [$clog2(MAX_PROCESSES)-1:0]  rd_addr,
   input  logic [$clog2(MAX_PROCESSES)-1:0]  rem_addr,
   input  logic [TIME_BITS-1:0]              rem_wdata,
   output logic [TIME_BITS-1:0]              arr_q,
   output logic [TIME_BITS-1:0]              burst_q,
   output logic [TIME_BITS-1:0]              rem_q
);

   import rrs_pkg::*;

   localparam int IW = $clog2(MAX_PROCESSES);

   logic [TIME_BITS-1:0] arrival_mem [MAX_PROCESSES];
   logic [TIME_BITS-1:0] burst_mem   [MAX_PROCESSES];
   logic [TIME_BITS-1:0] rem_mem     [MAX_PROCESSES];

   logic [MAX_PROCESSES-1:0] rem_vld_ff;
   logic [MAX_PROCESSES-1:0] rem_vld_in;
   logic [TIME_BITS-1:0]     arr_q_ff;
   logic [TIME_BITS-1:0]     burst_q_ff;
   logic [TIME_BITS-1:0]     rem_q_ff;
   logic                     rem_vq_ff;
   logic [IW-1:0]            load_idx;

   assign load_idx = IW'(load_addr);

   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         arrival_mem[load_idx] <= TIME_BITS'(load_arrival);
         burst_mem[load_idx]   <= TIME_BITS'(load_burst);
      end
      if (cmd.rem_we) begin
         rem_mem[rem_addr] <= rem_wdata;
      end
      arr_q_ff   <= arrival_mem[rd_addr];
      burst_q_ff <= burst_mem[rd_addr];
      rem_q_ff   <= rem_mem[rd_addr];
   end

   always_comb begin
      rem_vld_in = rem_vld_ff;
      if (cmd.rem_clr) begin
         rem_vld_in = '0;
      end
      if (cmd.rem_we) begin
         rem_vld_in[rem_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_vld_ff <= '0;
         rem_vq_ff  <= 1'b0;
      end else begin
         rem_vld_ff <= rem_vld_in;
         rem_vq_ff  <= rem_vld_ff[rd_addr];
      end
   end

   assign arr_q   = arr_q_ff;
   assign burst_q = burst_q_ff;
   assign rem_q   = rem_vq_ff ? rem_q_ff : '0;

endmodule

@@ design/rrs_engine.sv @@
// Scheduler sequencer: ready FIFO, run flags, counters and the step state machine.
// Depends on rrs_pkg and rrs_alu; reads the process table through rrs_table.

module rrs_engine #(
   parameter int MAX_PROCESSES = 8,
   parameter int TIME_BITS     = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_fire,
   input  rrs_pkg::req_word_type             req_word,
   input  logic [7:0]                        quantum,
   input  logic [3:0]                        process_count,
   output logic                              busy,
   output rrs_pkg::tbl_cmd_type              tbl_cmd,
   output logic [$clog2(MAX_PROCESSES)-1:0]  rd_addr,
   output logic [$clog2(MAX_PROCESSES)-1:0]  rem_addr,
   output logic [TIME_BITS-1:0]              rem_wdata,
   input  logic [TIME_BITS-1:0]              arr_q,
   input  logic [TIME_BITS-1:0]              burst_q,
   input  logic [TIME_BITS-1:0]              rem_q,
   output logic                              res_valid,
   output rrs_pkg::rsp_word_type             res_word,
   input  logic                              res_take
);

   import rrs_pkg::*;

   localparam int IW   = $clog2(MAX_PROCESSES);
   localparam int CNTW = $clog2(MAX_PROCESSES + 1);
   localparam int WIDE = (TIME_BITS > CLOCK_BITS) ? TIME_BITS : CLOCK_BITS;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_COPY   = 4'd1;
   localparam logic [3:0] S_SCAN   = 4'd2;
   localparam logic [3:0] S_MIN    = 4'd3;
   localparam logic [3:0] S_JUMP   = 4'd4;
   localparam logic [3:0] S_POP    = 4'd5;
   localparam logic [3:0] S_SLICE  = 4'd6;
   localparam logic [3:0] S_ADV    = 4'd7;
   localparam logic [3:0] S_REMSUB = 4'd8;
   localparam logic [3:0] S_POST   = 4'd9;
   localparam logic [3:0] S_TAT    = 4'd10;
   localparam logic [3:0] S_WT     = 4'd11;
   localparam logic [3:0] S_EMIT   = 4'd12;

   localparam logic [1:0] RET_START = 2'd0;
   localparam logic [1:0] RET_IDLE  = 2'd1;
   localparam logic [1:0] RET_DISP  = 2'd2;

   logic [3:0]               state_ff, state_in;
   logic [1:0]               ret_ff, ret_in;
   logic [IW-1:0]            idx_ff, idx_in;
   logic [IW-1:0]            proc_ff, proc_in;
   logic [MAX_PROCESSES-1:0] queued_ff, queued_in;
   logic [MAX_PROCESSES-1:0] done_ff, done_in;
   logic [IW-1:0]            head_ff, head_in;
   logic [IW-1:0]            tail_ff, tail_in;
   logic [CNTW-1:0]          fill_ff, fill_in;
   logic [CLOCK_BITS-1:0]    sim_ff, sim_in;
   logic                     prev_vld_ff, prev_vld_in;
   logic [IW-1:0]            prev_ff, prev_in;
   logic [CLOCK_BITS-1:0]    sw_ff, sw_in;
   logic [3:0]               fin_total_ff, fin_total_in;
   logic [TIME_BITS-1:0]     next_ff, next_in;
   logic                     found_ff, found_in;
   logic [7:0]               slice_ff, slice_in;
   logic                     rem_zero_ff, rem_zero_in;
   logic [1:0]               kind_ff, kind_in;
   logic                     fin_ff, fin_in;
   logic [CLOCK_BITS-1:0]    tat_ff, tat_in;
   logic [CLOCK_BITS-1:0]    wt_ff, wt_in;

   logic [IW-1:0]  fifo_mem [MAX_PROCESSES];
   logic [IW-1:0]  fifo_q_ff;
   logic           push_en;
   logic [IW-1:0]  push_val;
   logic           push_fire;

   logic [CNTW-1:0] live;
   logic            last;
   logic [7:0]      q_eff;
   logic            fresh;
   logic [WIDE-1:0] alu_a, alu_b;
   logic            alu_sub;
   logic [WIDE:0]   alu_res;
   logic            borrow;
   logic [TIME_BITS-1:0] rem_new;
   logic [31:0]     proc_wide;

   rrs_alu #(.WIDTH(WIDE)) u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .sub (alu_sub),
      .res (alu_res)
   );

   always_comb begin
      if (process_count == 4'd0) begin
         live = CNTW'(1);
      end else if (32'(process_count) > MAX_PROCESSES) begin
         live = CNTW'(MAX_PROCESSES);
      end else begin
         live = CNTW'(process_count);
      end
   end

   assign last    = (32'(idx_ff) + 32'd1) == 32'(live);
   assign q_eff   = (quantum == 8'd0) ? 8'd1 : quantum;
   assign fresh   = !done_ff[idx_ff] && !queued_ff[idx_ff];
   assign borrow  = alu_res[WIDE];
   assign rem_new = alu_res[TIME_BITS-1:0];

   // operand select for the shared unit
   always_comb begin
      alu_a   = WIDE'(sim_ff);
      alu_b   = WIDE'(arr_q);
      alu_sub = 1'b1;
      case (state_ff)
         S_MIN: begin
            alu_a = WIDE'(arr_q);
            alu_b = WIDE'(next_ff);
         end
         S_JUMP: begin
            alu_b = WIDE'(next_ff);
         end
         S_SLICE: begin
            alu_a = WIDE'(rem_q);
            alu_b = WIDE'(q_eff);
         end
         S_ADV: begin
            alu_b   = WIDE'(slice_ff);
            alu_sub = 1'b0;
         end
         S_REMSUB: begin
            alu_a = WIDE'(rem_q);
            alu_b = WIDE'(slice_ff);
         end
         S_WT: begin
            alu_a = WIDE'(tat_ff);
            alu_b = WIDE'(burst_q);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      idx_in       = idx_ff;
      proc_in      = proc_ff;
      queued_in    = queued_ff;
      done_in      = done_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      sim_in       = sim_ff;
      prev_vld_in  = prev_vld_ff;
      prev_in      = prev_ff;
      sw_in        = sw_ff;
      fin_total_in = fin_total_ff;
      next_in      = next_ff;
      found_in     = found_ff;
      slice_in     = slice_ff;
      rem_zero_in  = rem_zero_ff;
      kind_in      = kind_ff;
      fin_in       = fin_ff;
      tat_in       = tat_ff;
      wt_in        = wt_ff;
      push_en      = 1'b0;
      push_val     = idx_ff;
      tbl_cmd      = '0;
      rem_wdata    = burst_q;
      res_valid    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_word.operation)
                  OP_LOAD: begin
                     tbl_cmd.load_we = 32'(req_word.entry_index) < MAX_PROCESSES;
                  end
                  OP_START: begin
                     tbl_cmd.rem_clr = 1'b1;
                     queued_in    = '0;
                     done_in      = '0;
                     head_in      = '0;
                     fill_in      = '0;
                     sim_in       = '0;
                     prev_vld_in  = 1'b0;
                     sw_in        = '0;
                     fin_total_in = '0;
                     idx_in       = '0;
                     state_in     = S_COPY;
                  end
                  OP_STEP: begin
                     if (32'(fin_total_ff) >= 32'(live)) begin
                        kind_in  = KIND_DONE;
                        fin_in   = 1'b0;
                        state_in = S_EMIT;
                     end else if (fill_ff == '0) begin
                        idx_in   = '0;
                        found_in = 1'b0;
                        state_in = S_MIN;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_COPY: begin
            tbl_cmd.rem_we = 1'b1;
            rem_wdata      = burst_q;
            if (last) begin
               idx_in   = '0;
               ret_in   = RET_START;
               state_in = S_SCAN;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_SCAN: begin
            if (fresh && !borrow) begin
               queued_in[idx_ff] = 1'b1;
               push_en           = 1'b1;
               push_val          = idx_ff;
            end
            if (last) begin
               case (ret_ff)
                  RET_IDLE: begin
                     kind_in  = KIND_IDLE;
                     fin_in   = 1'b0;
                     state_in = S_EMIT;
                  end
                  RET_DISP: begin
                     idx_in   = proc_ff;
                     state_in = S_POST;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_MIN: begin
            if (fresh && (!found_ff || borrow)) begin
               next_in  = arr_q;
               found_in = 1'b1;
            end
            if (last) begin
               if (found_in) begin
                  state_in = S_JUMP;
               end else begin
                  kind_in  = KIND_DONE;
                  fin_in   = 1'b0;
                  state_in = S_EMIT;
               end
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_JUMP: begin
            if (borrow) begin
               sim_in = (WIDE'(next_ff) > WIDE'(CLOCK_MAX)) ? CLOCK_MAX
                                                           : CLOCK_BITS'(next_ff);
            end
            idx_in   = '0;
            ret_in   = RET_IDLE;
            state_in = S_SCAN;
         end
         S_POP: begin
            idx_in  = fifo_q_ff;
            proc_in = fifo_q_ff;
            head_in = (head_ff == IW'(MAX_PROCESSES - 1)) ? '0 : head_ff + IW'(1);
            fill_in = fill_ff - CNTW'(1);
            if (prev_vld_ff && prev_ff != fifo_q_ff && sw_ff != CLOCK_MAX) begin
               sw_in = sw_ff + CLOCK_BITS'(1);
            end
            prev_vld_in = 1'b1;
            prev_in     = fifo_q_ff;
            state_in    = S_SLICE;
         end
         S_SLICE: begin
            slice_in = borrow ? rem_q[7:0] : q_eff;
            state_in = S_ADV;
         end
         S_ADV: begin
            sim_in   = (|alu_res[WIDE:CLOCK_BITS]) ? CLOCK_MAX
                                                  : alu_res[CLOCK_BITS-1:0];
            state_in = S_REMSUB;
         end
         S_REMSUB: begin
            tbl_cmd.rem_we = 1'b1;
            rem_wdata      = rem_new;
            rem_zero_in    = rem_new == '0;
            idx_in         = '0;
            ret_in         = RET_DISP;
            state_in       = S_SCAN;
         end
         S_POST: begin
            kind_in = KIND_SLICE;
            if (!rem_zero_ff) begin
               push_en  = 1'b1;
               push_val = proc_ff;
               fin_in   = 1'b0;
               state_in = S_EMIT;
            end else begin
               done_in[proc_ff] = 1'b1;
               if (fin_total_ff != FIN_MAX) begin
                  fin_total_in = fin_total_ff + 4'd1;
               end
               fin_in   = 1'b1;
               state_in = S_TAT;
            end
         end
         S_TAT: begin
            tat_in   = borrow ? '0 : alu_res[CLOCK_BITS-1:0];
            state_in = S_WT;
         end
         S_WT: begin
            wt_in    = borrow ? '0 : alu_res[CLOCK_BITS-1:0];
            state_in = S_EMIT;
         end
         S_EMIT: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign push_fire = push_en && (32'(fill_ff) < MAX_PROCESSES);

   always_comb begin
      tail_in = tail_ff;
      if (state_ff == S_IDLE && req_fire && req_word.operation == OP_START) begin
         tail_in = '0;
      end else if (push_fire) begin
         tail_in = (tail_ff == IW'(MAX_PROCESSES - 1)) ? '0 : tail_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         fifo_mem[tail_ff] <= push_val;
      end
      fifo_q_ff <= fifo_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= RET_START;
         idx_ff       <= '0;
         proc_ff      <= '0;
         queued_ff    <= '0;
         done_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         sim_ff       <= '0;
         prev_vld_ff  <= 1'b0;
         prev_ff      <= '0;
         sw_ff        <= '0;
         fin_total_ff <= '0;
         found_ff     <= 1'b0;
         rem_zero_ff  <= 1'b0;
         kind_ff      <= KIND_DONE;
         fin_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         idx_ff       <= idx_in;
         proc_ff      <= proc_in;
         queued_ff    <= queued_in;
         done_ff      <= done_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= push_fire ? fill_in + CNTW'(1) : fill_in;
         sim_ff       <= sim_in;
         prev_vld_ff  <= prev_vld_in;
         prev_ff      <= prev_in;
         sw_ff        <= sw_in;
         fin_total_ff <= fin_total_in;
         found_ff     <= found_in;
         rem_zero_ff  <= rem_zero_in;
         kind_ff      <= kind_in;
         fin_ff       <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      next_ff  <= next_in;
      slice_ff <= slice_in;
      tat_ff   <= tat_in;
      wt_ff    <= wt_in;
   end

   assign busy     = state_ff != S_IDLE;
   assign rd_addr  = idx_in;
   assign rem_addr = idx_ff;
   assign proc_wide = 32'(proc_ff);

   always_comb begin
      res_word               = '0;
      res_word.step_kind     = kind_ff;
      res_word.time_now      = sim_ff;
      res_word.switch_count  = sw_ff;
      if (kind_ff == KIND_SLICE) begin
         res_word.process_index = proc_wide[2:0];
         res_word.slice_length  = slice_ff;
         res_word.finished      = fin_ff;
         if (fin_ff) begin
            res_word.turnaround = tat_ff;
            res_word.waiting    = wt_ff;
         end
      end
   end

   a_fifo_ptrs: assert property (@(posedge clock) disable iff (reset)
      (head_ff == tail_ff) == (fill_ff == '0 || 32'(fill_ff) == MAX_PROCESSES))
      else $error("ready queue pointers disagree with fill count");

   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= MAX_PROCESSES)
      else $error("ready queue overfilled");

   a_done_queued: assert property (@(posedge clock) disable iff (reset)
      (done_ff & ~queued_ff) == '0)
      else $error("finished entry was never queued");

   a_fin_total: assert property (@(posedge clock) disable iff (reset)
      32'(fin_total_ff) == (($countones(done_ff) > 15) ? 15 : $countones(done_ff)))
      else $error("finished count out of step with done flags");

   a_emit_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && res_take) |=> state_ff == S_IDLE)
      else $error("sequencer did not return to idle after result handoff");

endmodule
